@@ rtl/chbd_pkg.sv @@
// Shared types and constants of the canonical Huffman bit decoder.
`timescale 1ns / 1ps
`default_nettype none

package chbd_pkg;

    localparam int MAX_CODE_LEN  = 16;
    localparam int SYM_DEPTH     = 256;

    localparam int LEN_W      = 5;
    localparam int CNT_W      = 8;
    localparam int SYM_W      = 8;
    localparam int SLOT_W     = 8;
    localparam int STATUS_W   = 3;
    localparam int FREE_W     = 17;
    localparam int TOTAL_W    = 9;
    localparam int PCODE_W    = 16;
    localparam int FIRST_W    = 17;
    localparam int BASE_W     = 9;
    localparam int CNT_DEPTH  = MAX_CODE_LEN + 1;
    localparam int CNT_ADDR_W = $clog2(CNT_DEPTH);
    localparam int SYM_ADDR_W = $clog2(SYM_DEPTH);

    typedef enum logic [1:0] {
        CMD_COUNT  = 2'd0,
        CMD_SYMBOL = 2'd1,
        CMD_FINISH = 2'd2,
        CMD_DECODE = 2'd3
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_INVALID   = 3'd1,
        ST_OVERSUB   = 3'd2,
        ST_ALPHABET  = 3'd3,
        ST_BAD_ZERO  = 3'd4
    } t_status;

    typedef struct packed {
        t_cmd              command;
        logic [LEN_W-1:0]  length_slot;
        logic [CNT_W-1:0]  count_value;
        logic [SLOT_W-1:0] symbol_slot;
        logic [SYM_W-1:0]  symbol_value;
        logic              code_bit;
    } t_item;

    typedef struct packed {
        logic                  cnt_we;
        logic [CNT_ADDR_W-1:0] cnt_waddr;
        logic [CNT_W-1:0]      cnt_wdata;
        logic                  sym_we;
        logic [SYM_ADDR_W-1:0] sym_waddr;
        logic [SYM_W-1:0]      sym_wdata;
        logic                  sym_re;
        logic [SYM_ADDR_W-1:0] sym_raddr;
    } t_mem_req;

    typedef struct packed {
        logic    sym_valid;
        logic    bit_used;
        t_status status;
    } t_result;

endpackage

`default_nettype wire

@@ rtl/chbd_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module chbd_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [DATA_W-1:0]        i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [DATA_W-1:0]        o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

@@ rtl/chbd_engine.sv @@
// Table totals, walk registers and per-item next-state logic of the decoder.
`timescale 1ns / 1ps
`default_nettype none

module chbd_engine (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [chbd_pkg::LEN_W-1:0]       i_cfg_data,
    input  wire chbd_pkg::t_cmd                   i_in_cmd,
    input  wire chbd_pkg::t_item                  i_item,
    input  wire logic [chbd_pkg::CNT_W-1:0]       i_cnt_rdata,
    input  wire logic                             i_fire,
    output logic      [chbd_pkg::CNT_ADDR_W-1:0]  o_cnt_raddr,
    output chbd_pkg::t_mem_req                    o_req,
    output chbd_pkg::t_result                     o_res
);

    import chbd_pkg::*;

    logic [LEN_W-1:0]   r_max_len;
    logic [FREE_W-1:0]  r_free,    n_free;
    logic [TOTAL_W-1:0] r_total,   n_total;
    logic [PCODE_W-1:0] r_partial, n_partial;
    logic [FIRST_W-1:0] r_first,   n_first;
    logic [BASE_W-1:0]  r_base,    n_base;
    logic [LEN_W-1:0]   r_cur_len, n_cur_len;

    // Decode datapath
    logic [PCODE_W-1:0]   pcode;
    logic [FIRST_W-1:0]   diff;
    logic                 hit;
    logic [BASE_W:0]      idx;
    logic                 idx_ok;
    logic [FIRST_W:0]     fsum;
    logic [FIRST_W+1:0]   fnext;
    logic [FIRST_W-1:0]   first_adv;
    logic [BASE_W:0]      bsum;
    logic [BASE_W-1:0]    base_adv;
    logic [LEN_W-1:0]     len_inc;
    logic                 one_sym;

    assign pcode     = r_partial | PCODE_W'(i_item.code_bit);
    assign diff      = {1'b0, pcode} - r_first;
    assign hit       = ({1'b0, pcode} >= r_first) && (diff < FIRST_W'(i_cnt_rdata));
    assign idx       = {1'b0, r_base} + (BASE_W+1)'(diff[CNT_W-1:0]);
    assign idx_ok    = (idx < {1'b0, r_total}) && (idx < (BASE_W+1)'(SYM_DEPTH));
    // Saturate first code: once past every partial code it never matches again.
    assign fsum      = {1'b0, r_first} + (FIRST_W+1)'(i_cnt_rdata);
    assign fnext     = {fsum, 1'b0};
    assign first_adv = (|fnext[FIRST_W+1:FIRST_W]) ? {FIRST_W{1'b1}} : fnext[FIRST_W-1:0];
    assign bsum      = {1'b0, r_base} + (BASE_W+1)'(i_cnt_rdata);
    assign base_adv  = bsum[BASE_W] ? {BASE_W{1'b1}} : bsum[BASE_W-1:0];
    assign len_inc   = r_cur_len + LEN_W'(1);
    assign one_sym   = (r_max_len == '0) && (i_cnt_rdata == CNT_W'(1));

    // Length 0 serves finish and the one-symbol check; the walk reads its length.
    assign o_cnt_raddr = (i_in_cmd == CMD_DECODE && r_max_len != '0)
                       ? CNT_ADDR_W'(r_cur_len) : '0;

    // Count write limits
    logic [FREE_W-1:0]  free_base;
    logic [TOTAL_W-1:0] total_base;
    logic [TOTAL_W-1:0] room;
    logic [FREE_W-1:0]  free_dbl;
    logic               slot_zero;

    assign slot_zero  = (i_item.length_slot == '0);
    assign free_base  = slot_zero ? FREE_W'(1) : r_free;
    assign total_base = slot_zero ? '0 : r_total;
    assign room       = TOTAL_W'(SYM_DEPTH) - total_base;
    assign free_dbl   = free_base[FREE_W-1] ? {FREE_W{1'b1}} : {free_base[FREE_W-2:0], 1'b0};

    always_comb begin
        n_free    = r_free;
        n_total   = r_total;
        n_partial = r_partial;
        n_first   = r_first;
        n_base    = r_base;
        n_cur_len = r_cur_len;
        o_req     = '0;
        o_res     = '{sym_valid: 1'b0, bit_used: 1'b0, status: ST_OK};

        case (i_item.command)
            CMD_COUNT: begin
                if (i_item.length_slot <= r_max_len) begin
                    if (slot_zero) begin
                        n_free    = FREE_W'(1);
                        n_total   = '0;
                        n_partial = '0;
                        n_first   = '0;
                        n_base    = '0;
                        n_cur_len = LEN_W'(1);
                    end
                    o_req.cnt_we    = 1'b1;
                    o_req.cnt_waddr = CNT_ADDR_W'(i_item.length_slot);
                    o_req.cnt_wdata = '0;
                    if (TOTAL_W'(i_item.count_value) > room) begin
                        o_res.status = ST_ALPHABET;
                    end else if (!slot_zero && FREE_W'(i_item.count_value) > free_dbl) begin
                        o_res.status = ST_OVERSUB;
                    end else begin
                        n_free          = slot_zero ? free_base
                                        : free_dbl - FREE_W'(i_item.count_value);
                        n_total         = total_base + TOTAL_W'(i_item.count_value);
                        o_req.cnt_wdata = i_item.count_value;
                    end
                end
            end
            CMD_SYMBOL: begin
                o_req.sym_we    = 1'b1;
                o_req.sym_waddr = SYM_ADDR_W'(i_item.symbol_slot);
                o_req.sym_wdata = i_item.symbol_value;
            end
            CMD_FINISH: begin
                if (r_total == '0 ||
                    (i_cnt_rdata != '0 &&
                     (i_cnt_rdata != CNT_W'(1) || r_total != TOTAL_W'(1)))) begin
                    o_res.status = ST_BAD_ZERO;
                end
                n_partial = '0;
                n_first   = '0;
                n_base    = '0;
                n_cur_len = LEN_W'(1);
            end
            default: begin
                if (one_sym) begin
                    o_res.sym_valid = 1'b1;
                    o_req.sym_re    = 1'b1;
                    o_req.sym_raddr = '0;
                end else if (r_cur_len > r_max_len) begin
                    o_res.status = ST_INVALID;
                    n_partial    = '0;
                    n_first      = '0;
                    n_base       = '0;
                    n_cur_len    = LEN_W'(1);
                end else begin
                    o_res.bit_used = 1'b1;
                    if (hit) begin
                        if (idx_ok) begin
                            o_res.sym_valid = 1'b1;
                            o_req.sym_re    = 1'b1;
                            o_req.sym_raddr = idx[SYM_ADDR_W-1:0];
                        end else begin
                            o_res.status = ST_INVALID;
                        end
                        n_partial = '0;
                        n_first   = '0;
                        n_base    = '0;
                        n_cur_len = LEN_W'(1);
                    end else if (len_inc > r_max_len) begin
                        o_res.status = ST_INVALID;
                        n_partial    = '0;
                        n_first      = '0;
                        n_base       = '0;
                        n_cur_len    = LEN_W'(1);
                    end else begin
                        n_partial = pcode << 1;
                        n_first   = first_adv;
                        n_base    = base_adv;
                        n_cur_len = len_inc;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= '0;
        end else if (i_cfg_we) begin
            r_max_len <= (i_cfg_data > LEN_W'(MAX_CODE_LEN)) ? LEN_W'(MAX_CODE_LEN)
                                                             : i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free    <= FREE_W'(1);
            r_total   <= '0;
            r_partial <= '0;
            r_first   <= '0;
            r_base    <= '0;
            r_cur_len <= LEN_W'(1);
        end else if (i_fire) begin
            r_free    <= n_free;
            r_total   <= n_total;
            r_partial <= n_partial;
            r_first   <= n_first;
            r_base    <= n_base;
            r_cur_len <= n_cur_len;
        end
    end

endmodule

`default_nettype wire

@@ rtl/canonical_huffman_bit_decoder_core.sv @@
// Top level of the canonical Huffman bit decoder: item pipeline and table memories.
`timescale 1ns / 1ps
`default_nettype none

// Canonical Huffman decoder with a loaded table. Load the table with count
// items (ascending length, starting at length 0, after max_length is set),
// symbol items in canonical order and one finish item; then send one decode
// item per coded bit. Every item returns exactly one result item. Counts live
// in a 17-entry memory and symbols in a 256-entry memory, both with registered
// read data; neither is cleared, so entries must be written before use.
// An item reads the count memory as it is accepted, then in the walk stage
// updates the walk and table registers and issues the symbol memory read; the
// next item is held off until that walk stage completes, since its count
// address depends on it, so the core never accepts a new item while one is in
// the walk stage. A result stage and the output register let new items flow
// while a result waits on a stalled output.
module canonical_huffman_bit_decoder_core (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    // configuration: max_length
    input  wire logic       i_cfg_we,
    input  wire logic [4:0] i_cfg_data,
    // input items
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire logic [1:0] i_command,
    input  wire logic [4:0] i_length_slot,
    input  wire logic [7:0] i_count_value,
    input  wire logic [7:0] i_symbol_slot,
    input  wire logic [7:0] i_symbol_value,
    input  wire logic       i_code_bit,
    // result items
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output logic            o_symbol_valid,
    output logic [7:0]      o_decoded_symbol,
    output logic            o_bit_used,
    output logic [2:0]      o_status
);

    import chbd_pkg::*;

    // Walk stage: item whose count read is in flight or done
    logic            r_s1_valid;
    t_item           r_s1_item;
    // Result stage: walk done, symbol read in flight or done
    logic            r_s2_valid;
    t_result         r_s2_res;
    // Output register
    logic            r_out_valid;
    logic            r_out_sym_valid;
    logic [SYM_W-1:0] r_out_symbol;
    logic            r_out_bit_used;
    logic [STATUS_W-1:0] r_out_status;

    logic                  in_accept;
    logic                  out_load;
    logic                  s2_ready;
    logic                  s1_fire;
    t_cmd                  in_cmd;
    logic [CNT_ADDR_W-1:0] cnt_raddr;
    logic [CNT_W-1:0]      cnt_rdata;
    logic [SYM_W-1:0]      sym_rdata;
    t_mem_req              req;
    t_result               res;

    assign in_cmd     = t_cmd'(i_command);
    // Interlock: hold new items while the walk stage is occupied.
    assign o_in_stall = r_s1_valid;
    assign in_accept  = i_in_valid && !r_s1_valid;
    assign out_load   = r_s2_valid && (!r_out_valid || !i_out_stall);
    assign s2_ready   = !r_s2_valid || out_load;
    assign s1_fire    = r_s1_valid && s2_ready;

    chbd_ram #(
        .DATA_W (CNT_W),
        .DEPTH  (CNT_DEPTH)
    ) u_count_ram (
        .i_clk   (i_clk),
        .i_we    (s1_fire && req.cnt_we),
        .i_waddr (req.cnt_waddr),
        .i_wdata (req.cnt_wdata),
        .i_re    (in_accept),
        .i_raddr (cnt_raddr),
        .o_rdata (cnt_rdata)
    );

    chbd_ram #(
        .DATA_W (SYM_W),
        .DEPTH  (SYM_DEPTH)
    ) u_symbol_ram (
        .i_clk   (i_clk),
        .i_we    (s1_fire && req.sym_we),
        .i_waddr (req.sym_waddr),
        .i_wdata (req.sym_wdata),
        .i_re    (s1_fire && req.sym_re),
        .i_raddr (req.sym_raddr),
        .o_rdata (sym_rdata)
    );

    chbd_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_in_cmd    (in_cmd),
        .i_item      (r_s1_item),
        .i_cnt_rdata (cnt_rdata),
        .i_fire      (s1_fire),
        .o_cnt_raddr (cnt_raddr),
        .o_req       (req),
        .o_res       (res)
    );

    // Stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_fire) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_fire) begin
                r_s2_valid <= 1'b1;
            end else if (out_load) begin
                r_s2_valid <= 1'b0;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_item.command      <= in_cmd;
            r_s1_item.length_slot  <= i_length_slot;
            r_s1_item.count_value  <= i_count_value;
            r_s1_item.symbol_slot  <= i_symbol_slot;
            r_s1_item.symbol_value <= i_symbol_value;
            r_s1_item.code_bit     <= i_code_bit;
        end
        if (s1_fire) begin
            r_s2_res <= res;
        end
        if (out_load) begin
            r_out_sym_valid <= r_s2_res.sym_valid;
            r_out_symbol    <= r_s2_res.sym_valid ? sym_rdata : '0;
            r_out_bit_used  <= r_s2_res.bit_used;
            r_out_status    <= STATUS_W'(r_s2_res.status);
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_symbol_valid   = r_out_sym_valid;
    assign o_decoded_symbol = r_out_symbol;
    assign o_bit_used       = r_out_bit_used;
    assign o_status         = r_out_status;

endmodule

`default_nettype wire
